// File: design/rcs_pkg.sv
// Shared types, constants and the channel frequency table for the channel scanner.
// Used by the front, queue, back and top-level modules; no dependencies.
package rcs_pkg;

  localparam int NUM_CHANNELS = 48;
  localparam int TABLE_SIZE   = 48;
  localparam int CH_W         = 6;
  localparam int LEVEL_W      = 8;
  localparam int FREQ_W       = 13;
  localparam int LO_W         = FREQ_W - 1;
  localparam int DATA_W       = 20;
  localparam int FRAME_BITS   = 25;
  localparam int CNT_W        = $clog2(FRAME_BITS);
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [FREQ_W-1:0] IF_OFFSET  = FREQ_W'(479);
  localparam logic [3:0]        SYNTH_ADDR = 4'h1;
  localparam logic              WRITE_BIT  = 1'b1;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic               command;
    logic [LEVEL_W-1:0] rssi_level;
  } cmd_t;

  typedef struct packed {
    logic               serial_bit;
    logic               frame_last;
    logic [CH_W-1:0]    tuned_channel;
    logic               scan_done;
    logic [CH_W-1:0]    best_channel;
    logic [LEVEL_W-1:0] best_level;
  } frm_t;

  // One tuning request handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic               done;
    logic [CH_W-1:0]    best;
    logic [LEVEL_W-1:0] level;
  } job_t;

  function automatic logic [FREQ_W-1:0] freq_lookup(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] idx;
    logic [FREQ_W-1:0] f;
    // channels past the table wrap back onto it
    idx = (ch >= CH_W'(TABLE_SIZE)) ? ch - CH_W'(TABLE_SIZE) : ch;
    case (idx)
      6'd0:  f = 13'd5865;  6'd1:  f = 13'd5845;  6'd2:  f = 13'd5825;
      6'd3:  f = 13'd5805;  6'd4:  f = 13'd5785;  6'd5:  f = 13'd5765;
      6'd6:  f = 13'd5745;  6'd7:  f = 13'd5725;  6'd8:  f = 13'd5733;
      6'd9:  f = 13'd5752;  6'd10: f = 13'd5771;  6'd11: f = 13'd5790;
      6'd12: f = 13'd5809;  6'd13: f = 13'd5828;  6'd14: f = 13'd5847;
      6'd15: f = 13'd5866;  6'd16: f = 13'd5705;  6'd17: f = 13'd5685;
      6'd18: f = 13'd5665;  6'd19: f = 13'd5645;  6'd20: f = 13'd5885;
      6'd21: f = 13'd5905;  6'd22: f = 13'd5925;  6'd23: f = 13'd5945;
      6'd24: f = 13'd5740;  6'd25: f = 13'd5760;  6'd26: f = 13'd5780;
      6'd27: f = 13'd5800;  6'd28: f = 13'd5820;  6'd29: f = 13'd5840;
      6'd30: f = 13'd5860;  6'd31: f = 13'd5880;  6'd32: f = 13'd5658;
      6'd33: f = 13'd5695;  6'd34: f = 13'd5732;  6'd35: f = 13'd5769;
      6'd36: f = 13'd5806;  6'd37: f = 13'd5843;  6'd38: f = 13'd5880;
      6'd39: f = 13'd5917;  6'd40: f = 13'd5362;  6'd41: f = 13'd5399;
      6'd42: f = 13'd5436;  6'd43: f = 13'd5473;  6'd44: f = 13'd5510;
      6'd45: f = 13'd5547;  6'd46: f = 13'd5584;  6'd47: f = 13'd5621;
      default: f = 13'd5865;
    endcase
    return f;
  endfunction

  // Build the synthesizer word: address, write bit, then n << 7 | a
  function automatic logic [FRAME_BITS-1:0] tune_frame(input logic [CH_W-1:0] ch);
    logic [FREQ_W-1:0] diff;
    logic [LO_W-1:0]   lo;
    logic [DATA_W-1:0] data;
    diff = freq_lookup(ch) - IF_OFFSET;
    lo   = diff[FREQ_W-1:1];
    data = DATA_W'({lo[LO_W-1:5], 2'b00, lo[4:0]});
    return {data, WRITE_BIT, SYNTH_ADDR};
  endfunction

endpackage

// File: design/rssi_channel_scan_with_synth_frame_unit.sv
// Top level of the channel scanner: front end, request queue and frame shifter.
// Depends on rcs_pkg, rcs_front, rcs_queue and rcs_back.
//
//   channel  valid      stall      payload  role
//   command  cmd_valid  cmd_stall  cmd      start or signal strength sample in
//   frame    frm_valid  frm_stall  frm      one synthesizer frame bit out
//
// Each start or sample during a scan yields 25 frame bits, one per cycle from the
// back end's shift register when output is not stalled.
// The two-entry request queue lets the front take new commands while a frame shifts.
// A sample outside a scan is accepted and yields nothing.
// Synchronous reset clears the scan state, the queue and the shifter.
// cmd_stall rises only while the queue is full; frm_stall holds the current bit.
module rssi_channel_scan_with_synth_frame_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  rcs_pkg::cmd_t cmd,
  output logic          frm_valid,
  input  logic          frm_stall,
  output rcs_pkg::frm_t frm
);
  import rcs_pkg::*;

  logic push;
  job_t push_job;
  logic pop;
  logic q_full;
  logic q_valid;
  job_t q_head;

  rcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .q_full    (q_full),
    .cmd_stall (cmd_stall),
    .push      (push),
    .push_job  (push_job)
  );

  rcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  rcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_head),
    .pop       (pop),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_stall (frm_stall)
  );

endmodule

// File: design/rcs_front.sv
// Front end: accepts commands and samples, tracks the scan and the running best.
// Depends on rcs_pkg; pushes tuning requests into rcs_queue.
module rcs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  rcs_pkg::cmd_t cmd,
  input  logic          q_full,
  output logic          cmd_stall,
  output logic          push,
  output rcs_pkg::job_t push_job
);
  import rcs_pkg::*;

  logic               scan_active;
  logic [CH_W-1:0]    scan_index;
  logic [LEVEL_W-1:0] max_level;
  logic [CH_W-1:0]    best_index;

  logic               accept;
  logic               better;
  logic [LEVEL_W-1:0] max_next;
  logic [CH_W-1:0]    best_next;
  logic               more;

  assign cmd_stall = q_full;
  assign accept    = cmd_valid && !q_full;

  assign better    = cmd.rssi_level > max_level;
  assign max_next  = better ? cmd.rssi_level : max_level;
  assign best_next = better ? scan_index : best_index;
  assign more      = ({1'b0, scan_index} + (CH_W + 1)'(1)) < (CH_W + 1)'(NUM_CHANNELS);

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    if (accept) begin
      if (cmd.command == CMD_START) begin
        push     = 1'b1;
        push_job = '{channel: '0, done: 1'b0, best: best_index, level: '0};
      end else if (scan_active) begin
        push = 1'b1;
        if (more) begin
          push_job = '{channel: scan_index + CH_W'(1), done: 1'b0,
                       best: best_next, level: max_next};
        end else begin
          push_job = '{channel: best_next, done: 1'b1, best: best_next, level: max_next};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      scan_index  <= '0;
      max_level   <= '0;
      best_index  <= '0;
    end else if (accept) begin
      if (cmd.command == CMD_START) begin
        scan_active <= 1'b1;
        scan_index  <= '0;
        max_level   <= '0;
      end else if (scan_active) begin
        max_level  <= max_next;
        best_index <= best_next;
        if (more) begin
          scan_index <= scan_index + CH_W'(1);
        end else begin
          scan_active <= 1'b0;
        end
      end
    end
  end

endmodule

// File: design/rcs_queue.sv
// Short request queue between the front and back ends, held in flip-flops.
// Depends on rcs_pkg for the request type and depth.
module rcs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rcs_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output rcs_pkg::job_t head
);
  import rcs_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign full      = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

endmodule

// File: design/rcs_back.sv
// Back end: takes tuning requests, builds the synthesizer frame and shifts it out.
// Depends on rcs_pkg for the frame function and types.
module rcs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rcs_pkg::job_t q_job,
  output logic          pop,
  output logic          frm_valid,
  output rcs_pkg::frm_t frm,
  input  logic          frm_stall
);
  import rcs_pkg::*;

  logic                  active;
  logic [FRAME_BITS-1:0] shreg;
  logic [CNT_W-1:0]      cnt;
  job_t                  job;

  logic accept;
  logic last;

  assign last      = cnt == CNT_W'(FRAME_BITS - 1);
  assign accept    = active && !frm_stall;
  // load the next request as soon as the current frame's last bit leaves
  assign pop       = q_valid && (!active || (accept && last));
  assign frm_valid = active;

  always_comb begin
    frm.serial_bit    = shreg[0];
    frm.frame_last    = last;
    frm.tuned_channel = job.channel;
    frm.scan_done     = job.done;
    frm.best_channel  = job.best;
    frm.best_level    = job.level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (accept) begin
      if (last) begin
        active <= 1'b0;
      end
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      shreg <= tune_frame(q_job.channel);
      job   <= q_job;
    end else if (accept) begin
      shreg <= shreg >> 1;
    end
  end

endmodule
